[rtl/core/chbd_pkg.sv]
package chbd_pkg;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChVt    = 8'h0B;
  localparam logic [7:0] ChFf    = 8'h0C;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChLowX  = 8'h78;
  localparam logic [7:0] ChUpX   = 8'h58;

  // Gap end offsets past the LF: header line only, or final CR LF included
  localparam logic [31:0] GapEndHeader = 32'd1;
  localparam logic [31:0] GapEndLast   = 32'd3;

  localparam logic [31:0] MaxLenReset = 32'd1048576;

  localparam int unsigned TdataInW = 40;
  localparam int unsigned TdataOutW = 72;
  localparam int unsigned TuserOutW = 4;

  typedef enum logic [1:0] {
    ST_CONTINUE  = 2'd0,
    ST_HEADER    = 2'd1,
    ST_DONE_OK   = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    HP_BLANK  = 2'd0,
    HP_ZERO   = 2'd1,
    HP_DIGITS = 2'd2,
    HP_STOP   = 2'd3
  } hex_phase_e;

  typedef struct packed {
    logic [31:0] gap_end;
    logic [31:0] gap_start;
    logic        gap_valid;
    logic [7:0]  body_byte;
    logic        body_valid;
    status_e     status;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_digit_t;

  function automatic hex_digit_t hex_digit(input logic [7:0] c);
    hex_digit_t r;
    r = '0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.valid = 1'b1;
      r.value = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.valid = 1'b1;
      r.value = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.valid = 1'b1;
      r.value = 4'(c - 8'h37);
    end
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == ChSpace) || (c == ChTab) || (c == ChVt) || (c == ChFf);
  endfunction

endpackage

[rtl/core/chbd_size_parser.sv]
module chbd_size_parser #(
  parameter int unsigned LEN_WIDTH = 32
) (
  input  logic [7:0]           char_i,
  input  chbd_pkg::hex_phase_e phase_i,
  input  logic [LEN_WIDTH-1:0] value_i,
  output chbd_pkg::hex_phase_e phase_o,
  output logic [LEN_WIDTH-1:0] value_o
);
  import chbd_pkg::*;

  hex_digit_t           dig;
  logic [LEN_WIDTH-1:0] acc;

  assign dig = hex_digit(char_i);

  // Shift in one digit, pin at all ones once the top nibble is in use
  always_comb begin
    if (value_i[LEN_WIDTH-1 -: 4] != 4'd0) begin
      acc = '1;
    end else begin
      acc = {value_i[LEN_WIDTH-5:0], dig.value};
    end
  end

  always_comb begin
    phase_o = phase_i;
    value_o = value_i;
    case (phase_i)
      HP_BLANK: begin
        if (is_blank(char_i)) begin
          phase_o = HP_BLANK;
        end else if (char_i == ChZero) begin
          phase_o = HP_ZERO;
          value_o = '0;
        end else if (dig.valid) begin
          phase_o = HP_DIGITS;
          value_o = LEN_WIDTH'(dig.value);
        end else begin
          phase_o = HP_STOP;
        end
      end
      HP_ZERO: begin
        if (char_i == ChLowX || char_i == ChUpX) begin
          phase_o = HP_DIGITS;
        end else if (dig.valid) begin
          phase_o = HP_DIGITS;
          value_o = acc;
        end else begin
          phase_o = HP_STOP;
        end
      end
      HP_DIGITS: begin
        if (dig.valid) begin
          value_o = acc;
        end else begin
          phase_o = HP_STOP;
        end
      end
      default: begin
        phase_o = phase_i;
      end
    endcase
  end

endmodule

[rtl/core/chbd_out_buf.sv]
module chbd_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  chbd_pkg::result_t data_i,
  output logic              ready_o,
  output logic              valid_o,
  output chbd_pkg::result_t data_o,
  input  logic              ready_i
);
  import chbd_pkg::*;

  logic    valid_q;
  result_t data_q;

  // Free when empty or when the held transaction leaves this cycle
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && load_i) begin
      data_q <= data_i;
    end
  end

endmodule

[rtl/core/http_chunked_body_decoder.sv]
// Chunked transfer-encoding body decoder.
// Input channel (s_axis_*): one transaction per raw body byte, carrying the byte
// and its absolute stream position. Output channel (m_axis_*): exactly one
// transaction per input transaction, with a status code, an optional decoded
// payload byte and an optional framing gap range [gap_start, gap_end).
// Configuration: cfg_wr_en_i writes cfg_wr_data_i into max_content_length;
// write it only while the block is idle.
// Flow: a byte accepted sits in the input register, is decoded and lands in the
// output register, from which its result is taken. Throughput: one byte per
// cycle while the receiver does not stall, limited by the single decode stage
// between the input and output registers.
// Reset: all parse state clears, max_content_length returns to 1048576 and
// both registers empty. When the receiver stalls, the output register holds
// its transaction, the input register fills, and s_axis_tready drops once both
// are occupied; no transaction is lost or repeated.
// After a done status (ok or too large) every further byte gives a continue
// status with nothing attached until the next reset.
module http_chunked_body_decoder #(
  parameter int unsigned LEN_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [31:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] data_byte, [39:8] byte_index
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [7:0] body_byte, [39:8] gap_start, [71:40] gap_end
  output logic [3:0]  m_axis_tuser    // [1:0] status, [2] body_valid, [3] gap_valid
);
  import chbd_pkg::*;

  localparam int unsigned CmpW = (LEN_WIDTH > 32) ? LEN_WIDTH : 32;

  // Input register
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic [31:0] in_pos_q;

  // Parse state
  logic                 data_mode_q, data_mode_d;
  logic                 finished_q, finished_d;
  logic                 line_nonempty_q, line_nonempty_d;
  hex_phase_e           phase_q, phase_d;
  logic [LEN_WIDTH-1:0] hex_value_q, hex_value_d;
  logic [LEN_WIDTH-1:0] total_q, total_d;
  logic [LEN_WIDTH-1:0] body_count_q, body_count_d;
  logic                 gap_open_q, gap_open_d;
  logic [31:0]          gap_begin_q, gap_begin_d;
  logic [31:0]          max_len_q;

  hex_phase_e           pr_phase;
  logic [LEN_WIDTH-1:0] pr_value;
  logic [LEN_WIDTH-1:0] size;
  logic [LEN_WIDTH:0]   sum;
  logic [LEN_WIDTH-1:0] total_sat;
  logic [LEN_WIDTH-1:0] count_inc;
  logic [31:0]          gap_base;
  logic                 too_large;

  logic    out_ready;
  logic    advance;
  result_t res;
  result_t out_data;

  // Decode an item only when its result has a place to go
  assign advance       = in_valid_q && out_ready;
  assign s_axis_tready = !in_valid_q || out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_pos_q  <= s_axis_tdata[39:8];
    end
  end

  chbd_size_parser #(
    .LEN_WIDTH (LEN_WIDTH)
  ) u_parser (
    .char_i  (in_byte_q),
    .phase_i (phase_q),
    .value_i (hex_value_q),
    .phase_o (pr_phase),
    .value_o (pr_value)
  );

  // A line with no digits reads as size zero
  assign size      = (phase_q == HP_BLANK) ? '0 : hex_value_q;
  assign sum       = {1'b0, total_q} + {1'b0, size};
  assign total_sat = sum[LEN_WIDTH] ? '1 : sum[LEN_WIDTH-1:0];
  assign too_large = CmpW'(total_sat) > CmpW'(max_len_q);
  assign count_inc = body_count_q + LEN_WIDTH'(1);
  // The gap opens at this byte if none is open yet
  assign gap_base  = gap_open_q ? gap_begin_q : in_pos_q;

  always_comb begin
    data_mode_d     = data_mode_q;
    finished_d      = finished_q;
    line_nonempty_d = line_nonempty_q;
    phase_d         = phase_q;
    hex_value_d     = hex_value_q;
    total_d         = total_q;
    body_count_d    = body_count_q;
    gap_open_d      = gap_open_q;
    gap_begin_d     = gap_begin_q;
    res             = '0;
    res.status      = ST_CONTINUE;

    if (finished_q) begin
      // drop everything until reset
    end else if (data_mode_q) begin
      res.body_valid = 1'b1;
      res.body_byte  = in_byte_q;
      body_count_d   = count_inc;
      if (count_inc == total_q) begin
        data_mode_d = 1'b0;
      end
    end else begin
      gap_open_d  = 1'b1;
      gap_begin_d = gap_base;
      if (in_byte_q == ChLf && line_nonempty_q) begin
        line_nonempty_d = 1'b0;
        phase_d         = HP_BLANK;
        hex_value_d     = '0;
        if (size != '0) begin
          total_d = total_sat;
          if (too_large) begin
            res.status = ST_TOO_LARGE;
            finished_d = 1'b1;
          end else begin
            res.status    = ST_HEADER;
            data_mode_d   = 1'b1;
            res.gap_valid = 1'b1;
            res.gap_start = gap_base;
            res.gap_end   = in_pos_q + GapEndHeader;
            gap_open_d    = 1'b0;
          end
        end else begin
          res.status    = ST_DONE_OK;
          finished_d    = 1'b1;
          res.gap_valid = 1'b1;
          res.gap_start = gap_base;
          res.gap_end   = in_pos_q + GapEndLast;
          gap_open_d    = 1'b0;
        end
      end else if (in_byte_q != ChCr && in_byte_q != ChLf) begin
        line_nonempty_d = 1'b1;
        phase_d         = pr_phase;
        hex_value_d     = pr_value;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_mode_q     <= 1'b0;
      finished_q      <= 1'b0;
      line_nonempty_q <= 1'b0;
      phase_q         <= HP_BLANK;
      hex_value_q     <= '0;
      total_q         <= '0;
      body_count_q    <= '0;
      gap_open_q      <= 1'b0;
      gap_begin_q     <= '0;
    end else if (advance) begin
      data_mode_q     <= data_mode_d;
      finished_q      <= finished_d;
      line_nonempty_q <= line_nonempty_d;
      phase_q         <= phase_d;
      hex_value_q     <= hex_value_d;
      total_q         <= total_d;
      body_count_q    <= body_count_d;
      gap_open_q      <= gap_open_d;
      gap_begin_q     <= gap_begin_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MaxLenReset;
    end else if (cfg_wr_en_i) begin
      max_len_q <= cfg_wr_data_i;
    end
  end

  chbd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (in_valid_q),
    .data_i  (res),
    .ready_o (out_ready),
    .valid_o (m_axis_tvalid),
    .data_o  (out_data),
    .ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {out_data.gap_end, out_data.gap_start, out_data.body_byte};
  assign m_axis_tuser = {out_data.gap_valid, out_data.body_valid, out_data.status};

endmodule

[rtl/core/chbd_checker.sv]
module chbd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser
);
  import chbd_pkg::*;

  // Hold a stalled result transaction
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output transaction changed while stalled");

  // Payload bytes never carry a gap or a status
  a_body_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[2] |->
      !m_axis_tuser[3] && m_axis_tuser[1:0] == ST_CONTINUE)
    else $error("payload byte mixed with framing result");

  // A gap closes only on a header or a clean finish
  a_gap_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[3] |->
      m_axis_tuser[1:0] == ST_HEADER || m_axis_tuser[1:0] == ST_DONE_OK)
    else $error("gap reported with wrong status");

  // Fields not flagged valid read as zero
  a_zero_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |->
      (m_axis_tuser[2] || m_axis_tdata[7:0] == 8'd0) &&
      (m_axis_tuser[3] || m_axis_tdata[71:8] == 64'd0))
    else $error("unflagged field not zero");

endmodule

bind http_chunked_body_decoder chbd_checker u_chbd_checker (.*);

[tb/tb_http_chunked_body_decoder.sv]
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
  import chbd_pkg::*;

  localparam int unsigned RandomItems = 1130;
  localparam int unsigned PhaseItems  = 200;
  localparam int unsigned LongHold    = 300;
  localparam int unsigned HoldAfter   = 450;
  localparam int unsigned LatencyPad  = 6;
  localparam int unsigned CycleLimit  = 1_000_000;

  // Decoder model plus the queue of results it still owes.
  class chunk_scoreboard;
    logic [31:0] max_len;
    bit          in_data;
    bit          finished;
    bit          line_nonempty;
    hex_phase_e  hex_state;
    logic [31:0] hex_val;
    logic [31:0] total_len;
    logic [31:0] body_cnt;
    bit          gap_open;
    logic [31:0] gap_begin;
    result_t     pending[$];
    int unsigned failures;

    function new();
      max_len       = MaxLenReset;
      in_data       = 1'b0;
      finished      = 1'b0;
      line_nonempty = 1'b0;
      hex_state     = HP_BLANK;
      hex_val       = '0;
      total_len     = '0;
      body_cnt      = '0;
      gap_open      = 1'b0;
      gap_begin     = '0;
      failures      = 0;
    endfunction

    static function bit nibble_of(input logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c >= "0" && c <= "9") v = 4'(c - "0");
      else if (c >= "a" && c <= "f") v = 4'(c - "a" + 8'd10);
      else if (c >= "A" && c <= "F") v = 4'(c - "A" + 8'd10);
      else return 1'b0;
      return 1'b1;
    endfunction

    function void shift_in(input logic [3:0] v);
      if (hex_val > 32'h0FFF_FFFF) hex_val = '1;
      else hex_val = {hex_val[27:0], v};
    endfunction

    // One character of a size line, CR and LF excluded.
    function void size_char(input logic [7:0] c);
      logic [3:0] v;
      bit         is_hex;
      is_hex = nibble_of(c, v);
      line_nonempty = 1'b1;
      case (hex_state)
        HP_BLANK: begin
          if (c == ChSpace || c == ChTab || c == ChVt || c == ChFf) return;
          if (c == ChZero) begin
            hex_state = HP_ZERO;
            hex_val   = '0;
          end else if (is_hex) begin
            hex_state = HP_DIGITS;
            hex_val   = 32'(v);
          end else begin
            hex_state = HP_STOP;
          end
        end
        HP_ZERO: begin
          if (c == ChLowX || c == ChUpX) hex_state = HP_DIGITS;
          else if (is_hex) begin
            hex_state = HP_DIGITS;
            shift_in(v);
          end else hex_state = HP_STOP;
        end
        HP_DIGITS: begin
          if (is_hex) shift_in(v);
          else hex_state = HP_STOP;
        end
        default: ;
      endcase
    endfunction

    function void note_byte(input logic [7:0] c, input logic [31:0] pos);
      result_t     r;
      logic [31:0] chunk_len;
      logic [32:0] sum;
      r = '0;
      r.status = ST_CONTINUE;
      if (finished) begin
        // drop everything after the body is done
      end else if (in_data) begin
        r.body_valid = 1'b1;
        r.body_byte  = c;
        body_cnt     = body_cnt + 32'd1;
        if (body_cnt == total_len) in_data = 1'b0;
      end else begin
        if (!gap_open) begin
          gap_open  = 1'b1;
          gap_begin = pos;
        end
        if (c == ChLf && line_nonempty) begin
          chunk_len     = (hex_state == HP_BLANK) ? '0 : hex_val;
          line_nonempty = 1'b0;
          hex_state     = HP_BLANK;
          hex_val       = '0;
          if (chunk_len != '0) begin
            sum       = {1'b0, total_len} + {1'b0, chunk_len};
            total_len = sum[32] ? '1 : sum[31:0];
            if (total_len > max_len) begin
              r.status = ST_TOO_LARGE;
              finished = 1'b1;
            end else begin
              r.status    = ST_HEADER;
              in_data     = 1'b1;
              r.gap_valid = 1'b1;
              r.gap_start = gap_begin;
              r.gap_end   = pos + GapEndHeader;
              gap_open    = 1'b0;
            end
          end else begin
            r.status    = ST_DONE_OK;
            finished    = 1'b1;
            r.gap_valid = 1'b1;
            r.gap_start = gap_begin;
            r.gap_end   = pos + GapEndLast;
            gap_open    = 1'b0;
          end
        end else if (c != ChCr && c != ChLf) begin
          size_char(c);
        end
      end
      pending = {pending, r};
    endfunction

    function void flag(input string what, input logic [31:0] want, input logic [31:0] got);
      failures++;
      if (failures <= 10)
        $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
    endfunction

    function void check_result(input logic [3:0] user, input logic [71:0] data);
      result_t want;
      if (pending.size() == 0) begin
        failures++;
        if (failures <= 10) $display("%0t: result transaction with none pending", $time);
        return;
      end
      want = pending.pop_front();
      if (user[1:0] != want.status) flag("status", 32'(want.status), 32'(user[1:0]));
      if (user[2] != want.body_valid) flag("body_valid", 32'(want.body_valid), 32'(user[2]));
      if (data[7:0] != want.body_byte) flag("body_byte", 32'(want.body_byte), 32'(data[7:0]));
      if (user[3] != want.gap_valid) flag("gap_valid", 32'(want.gap_valid), 32'(user[3]));
      if (data[39:8] != want.gap_start) flag("gap_start", want.gap_start, data[39:8]);
      if (data[71:40] != want.gap_end) flag("gap_end", want.gap_end, data[71:40]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n    = 1'b0;
  logic        cfg_we   = 1'b0;
  logic [31:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [71:0] m_tdata;
  logic [3:0]  m_tuser;

  chunk_scoreboard sb = new();

  logic [31:0] pos             = '0;  // stream position of the next byte to send
  int unsigned bytes_sent      = 0;
  int unsigned inputs_accepted = 0;
  int unsigned calm_left       = 0;   // bytes left in a stretch with no sender gaps
  int unsigned cycles          = 0;

  http_chunked_body_decoder dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_wr_en_i   (cfg_we),
    .cfg_wr_data_i (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),   // [7:0] data_byte, [39:8] byte_index
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),   // [7:0] body_byte, [39:8] gap_start, [71:40] gap_end
    .m_axis_tuser  (m_tuser)    // [1:0] status, [2] body_valid, [3] gap_valid
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    logic [7:0] base;
    if (v < 4'd10) return ChZero + 8'(v);
    base = upper ? "A" : "a";
    return base + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0:       return ChSpace;
      1:       return ChTab;
      2:       return ChVt;
      default: return ChFf;
    endcase
  endfunction

  function automatic int unsigned chunk_len_pick();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 24);
    if (r < 98) return $urandom_range(25, 64);
    return $urandom_range(200, 300);
  endfunction

  // Sample both channels at the edge; inputs change only after it.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        sb.note_byte(s_tdata[7:0], s_tdata[39:8]);
        inputs_accepted++;
      end
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
    end
  end

  // Receiver: bursts of ready with random stalls, plus one long hold-off while the
  // sender keeps offering, so that both registers fill and tready drops.
  initial begin : receiver
    int unsigned burst;
    int unsigned stall;
    bit          held;
    held = 1'b0;
    wait (rst_n);
    forever begin
      if (!held && inputs_accepted >= HoldAfter && s_tvalid) begin
        held = 1'b1;
        m_tready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 20);
      m_tready <= 1'b1;
      repeat (burst) @(posedge clk);
      stall = idle_len();
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Offer one byte at the current position and hold it until accepted.
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (calm_left != 0) begin
      calm_left--;
      gap = 0;
    end else begin
      gap = idle_len();
      if ($urandom_range(0, 49) == 0) calm_left = $urandom_range(40, 150);
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {pos, b};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pos = pos + 32'd1;
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_crlf();
    send_byte(ChCr);
    send_byte(ChLf);
  endtask

  // Stop offering, wait for every pending result, then let the pipeline settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LatencyPad) @(posedge clk);
  endtask

  // Write max_content_length; call only with the block idle.
  task automatic write_max_len(input logic [31:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.max_len = v;
  endtask

  // One whole chunk: size line with random dressing, payload, trailing framing.
  task automatic send_chunk(input int unsigned len);
    int unsigned n_digits;
    int unsigned pick;
    logic [7:0]  junk;
    logic [3:0]  unused_nib;
    pick = $urandom_range(0, 15);
    if (pick == 0) pos = $urandom;
    else if (pick == 1) pos = 32'hFFFF_FFF0 + $urandom_range(0, 15);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_byte(blank_char());
    case ($urandom_range(0, 5))
      0:       send_text("0x");
      1:       send_text("0X");
      2:       repeat ($urandom_range(1, 3)) send_byte(ChZero);
      default: ;
    endcase
    n_digits = 1;
    while ((len >> (4 * n_digits)) != 0) n_digits++;
    for (int i = int'(n_digits) - 1; i >= 0; i--)
      send_byte(hex_char(4'(len >> (4 * i)), 1'($urandom_range(0, 1))));
    // Extension junk: first char stops the parse, the rest is ignored up to LF.
    if ($urandom_range(0, 2) == 0) begin
      do junk = 8'($urandom_range(0, 255));
      while (chunk_scoreboard::nibble_of(junk, unused_nib) || junk == ChCr || junk == ChLf);
      send_byte(junk);
      repeat ($urandom_range(0, 4)) begin
        do junk = 8'($urandom_range(0, 255)); while (junk == ChLf);
        send_byte(junk);
      end
    end
    case ($urandom_range(0, 7))
      0: send_byte(ChLf);
      1: begin
        send_byte(ChCr);
        send_crlf();
      end
      default: send_crlf();
    endcase
    repeat (len) send_byte(8'($urandom_range(0, 255)));
    case ($urandom_range(0, 7))
      0: send_byte(ChLf);
      1: begin
        send_crlf();
        send_crlf();
      end
      2: begin
        send_crlf();
        send_byte(ChLf);
      end
      3: ;
      default: send_crlf();
    endcase
  endtask

  initial begin : stimulus
    int unsigned phase_no;
    int unsigned phase_end;
    int unsigned tight_len;
    phase_no  = 0;
    tight_len = 1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: all four blanks, lowercase prefix, gap opening at position zero,
    // payload extremes, empty lines across the position wrap, uppercase prefix
    // with a stop character.
    pos = '0;
    send_byte(ChTab);
    send_byte(ChSpace);
    send_byte(ChVt);
    send_byte(ChFf);
    send_text("0x2");
    send_crlf();
    send_byte(8'h00);
    send_byte(8'hFF);
    pos = 32'hFFFF_FFFD;
    send_crlf();
    send_byte(ChLf);
    send_text("0X1g");
    send_crlf();
    send_byte(8'h5A);

    // Random phases, each under its own length limit. The tight phase sets the
    // limit to exactly the total after one more chunk.
    while (bytes_sent < RandomItems) begin
      drain();
      case (phase_no % 5)
        0: write_max_len(32'hFFFF_FFFF);
        1: write_max_len($urandom_range(32'hFFFF_FFFE, 32'h0001_0000));
        2: begin
          tight_len = $urandom_range(1, 6);
          write_max_len(sb.total_len + tight_len);
        end
        3: write_max_len(MaxLenReset);
        default: write_max_len($urandom | 32'h0001_0000);
      endcase
      phase_end = bytes_sent + PhaseItems;
      if (phase_no % 5 == 2) send_chunk(tight_len);
      else
        while (bytes_sent < phase_end && bytes_sent < RandomItems)
          send_chunk(chunk_len_pick());
      phase_no++;
    end

    // Finish the body under a zero limit: either a zero-size line in one of its
    // forms, or a size that saturates and overflows the total.
    drain();
    write_max_len('0);
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 6))
        0: send_text("0");
        1: send_text("000");
        2: send_text("0x");
        3: send_text("0X0;ext=1");
        4: begin
          send_byte(ChSpace);
          send_byte(ChTab);
        end
        5: send_text(";note");
        default: send_text("z9");
      endcase
    end else begin
      if ($urandom_range(0, 1) == 0) send_text("0x");
      send_byte(hex_char(4'($urandom_range(1, 15)), 1'($urandom_range(0, 1))));
      repeat ($urandom_range(8, 11))
        send_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end
    send_crlf();
    send_crlf();
    // Bytes after the end of the body must be ignored.
    repeat (16) send_byte(8'($urandom_range(0, 255)));
    drain();

    if (sb.failures == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/chbd_pkg.sv
rtl/core/chbd_size_parser.sv
rtl/core/chbd_out_buf.sv
rtl/core/http_chunked_body_decoder.sv
rtl/core/chbd_checker.sv
tb/tb_http_chunked_body_decoder.sv
